// ===== rtl/lzrep_pkg.sv =====
// Shared codes and types for the repeat-offset LZ77 decoder.
`timescale 1ns / 1ps

package lzrep_pkg;

	localparam int OFS_W = 17;
	localparam int LEN_W = 10;

	typedef logic [7:0]       byte_t;
	typedef logic [OFS_W-1:0] offset_t;
	typedef logic [1:0]       action_t;
	typedef logic [1:0]       rep_kind_t;

	// action codes
	localparam action_t ACT_LIT   = 2'd0;
	localparam action_t ACT_MATCH = 2'd1;
	localparam action_t ACT_PRE   = 2'd2;

	// match offset sources
	localparam rep_kind_t REP_0   = 2'd0;
	localparam rep_kind_t REP_1   = 2'd1;
	localparam rep_kind_t REP_2   = 2'd2;
	localparam rep_kind_t REP_NEW = 2'd3;

endpackage

// ===== rtl/lzrep_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lzrep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lz_rep_offset_decoder_unit.sv =====
// Top level: LZ77 decoder with three repeat offsets and a ring history in RAM.
// Literal and preload items are taken while idle; a literal result shows in the cycle after accept.
// A match of L bytes (L after clamping) moves one byte per cycle while the output does not stall,
// through the history RAM read-modify-write loop behind the registered RAM read.
// Error and zero-length matches do not enter the copy loop. Output stalls pause the copy loop.
// Reset clears offsets, fill count and write pointer; history contents are undefined until written.
`timescale 1ns / 1ps

module lz_rep_offset_decoder_unit #(
	parameter int WINDOW_SIZE = 65536,
	parameter int MAX_MATCH   = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  literal_byte,
	input  logic [1:0]  rep_kind,
	input  logic [16:0] new_offset,
	input  logic [9:0]  match_length,
	input  logic        block_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] data_bytes,
	output logic [3:0]  byte_count,
	output logic        last,
	output logic        error
);

	// window must be a power of two, which the block does not check: ring pointers wrap naturally
	localparam int AW = $clog2(WINDOW_SIZE);
	localparam int FW = $clog2(WINDOW_SIZE + 1);
	localparam int OW = lzrep_pkg::OFS_W;
	localparam int CW = (FW > OW) ? FW : OW;
	localparam int LW = $clog2(MAX_MATCH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_COPY = 1'b1;

	logic                   state_q;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          rp_q;
	logic [FW-1:0]          fill_q;
	lzrep_pkg::offset_t     rep0_q, rep1_q, rep2_q;
	logic [LW-1:0]          iss_left_q;
	logic [LW-1:0]          wr_left_q;
	logic                   v_s1;
	logic                   dist1_q;
	logic                   first_q;
	lzrep_pkg::byte_t       last_b_q;
	logic [63:0]            word_q;
	logic [2:0]             cnt_q;

	logic                   out_valid_q;
	logic [63:0]            data_q;
	logic [3:0]             count_q;
	logic                   last_q;
	logic                   err_q;

	logic                   accept;
	logic                   adv;
	logic                   is_byte_item;
	logic                   is_match;
	lzrep_pkg::offset_t     r0e, r1e, r2e;
	lzrep_pkg::offset_t     nrep0, nrep1, nrep2;
	lzrep_pkg::offset_t     match_dist;
	logic [FW-1:0]          fill_eff;
	logic                   dist_bad;
	logic [LW-1:0]          len_sat;
	logic                   issue;
	logic                   produce;
	lzrep_pkg::byte_t       rd_data;
	lzrep_pkg::byte_t       cp_byte;
	logic [63:0]            word_put;
	logic                   cp_last;
	logic                   cp_push;
	logic                   push_acc;
	logic                   ram_we;
	lzrep_pkg::byte_t       ram_wdata;

	function automatic logic [FW-1:0] fill_inc(input logic [FW-1:0] f);
		fill_inc = (f == FW'(WINDOW_SIZE)) ? f : f + 1'b1;
	endfunction

	assign accept   = in_valid && !in_stall;
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);

	assign is_byte_item = (action == lzrep_pkg::ACT_LIT) || (action == lzrep_pkg::ACT_PRE);
	assign is_match     = (action == lzrep_pkg::ACT_MATCH);

	// offset list update and distance check for the incoming item
	always_comb begin
		r0e        = block_start ? '0 : rep0_q;
		r1e        = block_start ? '0 : rep1_q;
		r2e        = block_start ? '0 : rep2_q;
		fill_eff   = block_start ? '0 : fill_q;
		nrep0      = r0e;
		nrep1      = r1e;
		nrep2      = r2e;
		match_dist = r0e;
		if (is_match) begin
			unique case (rep_kind)
				lzrep_pkg::REP_0: begin
					match_dist = r0e;
				end
				lzrep_pkg::REP_1: begin
					match_dist = r1e;
					nrep0      = r1e;
					nrep1      = r0e;
				end
				lzrep_pkg::REP_2: begin
					match_dist = r2e;
					nrep0      = r2e;
					nrep1      = r0e;
					nrep2      = r1e;
				end
				lzrep_pkg::REP_NEW: begin
					match_dist = new_offset;
					nrep0      = new_offset;
					nrep1      = r0e;
					nrep2      = r1e;
				end
			endcase
		end
		dist_bad = (match_dist == '0) || (CW'(match_dist) > CW'(fill_eff));
		len_sat  = (match_length > 10'(MAX_MATCH)) ? LW'(MAX_MATCH) : LW'(match_length);
	end

	assign push_acc = accept && ((action == lzrep_pkg::ACT_LIT) ||
		(is_match && (dist_bad || (len_sat == '0))));

	// copy loop: s0 issues the history read, s1 writes the byte back and packs it
	assign issue   = (state_q == ST_COPY) && adv && (iss_left_q != '0);
	assign produce = (state_q == ST_COPY) && adv && v_s1;
	// distance one: the source is the byte written in the same cycle, so reuse it
	assign cp_byte = (dist1_q && !first_q) ? last_b_q : rd_data;
	assign cp_last = (wr_left_q == LW'(1));
	assign cp_push = produce && ((cnt_q == 3'd7) || cp_last);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			word_put[8*i +: 8] = (cnt_q == 3'(i)) ? cp_byte : word_q[8*i +: 8];
		end
	end

	assign ram_we    = (accept && is_byte_item) || produce;
	assign ram_wdata = produce ? cp_byte : literal_byte;

	lzrep_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_SIZE)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rp_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			rp_q       <= '0;
			fill_q     <= '0;
			rep0_q     <= '0;
			rep1_q     <= '0;
			rep2_q     <= '0;
			iss_left_q <= '0;
			wr_left_q  <= '0;
			v_s1       <= 1'b0;
			dist1_q    <= 1'b0;
			first_q    <= 1'b0;
			last_b_q   <= '0;
			word_q     <= '0;
			cnt_q      <= '0;
		end else if (accept) begin
			rep0_q <= nrep0;
			rep1_q <= nrep1;
			rep2_q <= nrep2;
			fill_q <= is_byte_item ? fill_inc(fill_eff) : fill_eff;
			if (is_byte_item) begin
				wp_q <= wp_q + 1'b1;
			end
			if (is_match && !dist_bad && (len_sat != '0)) begin
				state_q    <= ST_COPY;
				iss_left_q <= len_sat;
				wr_left_q  <= len_sat;
				v_s1       <= 1'b0;
				first_q    <= 1'b1;
				dist1_q    <= (match_dist == OW'(1));
				rp_q       <= wp_q - AW'(match_dist);
			end
		end else if (state_q == ST_COPY && adv) begin
			v_s1 <= issue;
			if (issue) begin
				rp_q       <= rp_q + 1'b1;
				iss_left_q <= iss_left_q - LW'(1);
			end
			if (produce) begin
				wp_q      <= wp_q + 1'b1;
				fill_q    <= fill_inc(fill_q);
				wr_left_q <= wr_left_q - LW'(1);
				first_q   <= 1'b0;
				last_b_q  <= cp_byte;
				if (cp_push) begin
					cnt_q  <= '0;
					word_q <= '0;
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					word_q <= word_put;
				end
				if (cp_last) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_acc || cp_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_acc) begin
			data_q  <= (action == lzrep_pkg::ACT_LIT) ? 64'(literal_byte) : '0;
			count_q <= (action == lzrep_pkg::ACT_LIT) ? 4'd1 : 4'd0;
			last_q  <= 1'b1;
			err_q   <= is_match && dist_bad;
		end else if (cp_push) begin
			data_q  <= word_put;
			count_q <= {1'b0, cnt_q} + 4'd1;
			last_q  <= cp_last;
			err_q   <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_bytes = data_q;
	assign byte_count = count_q;
	assign last       = last_q;
	assign error      = err_q;

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> (byte_count == 4'd0) && last)
		else $error("error transaction carries data or is not last");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (byte_count == 4'd8))
		else $error("non-final transaction is not a full word");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_SIZE))
		else $error("fill count beyond window");

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> (wr_left_q >= iss_left_q) &&
		((wr_left_q - iss_left_q) <= LW'(1)))
		else $error("copy read and write counts drifted apart");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !v_s1 && (iss_left_q == '0) && (wr_left_q == '0))
		else $error("copy work left over in idle");

endmodule

// ===== bench/tb_lz_rep_offset_decoder_unit.sv =====
// Self-checking bench for the repeat-offset LZ77 decoder with a built-in byte-level predictor.
`timescale 1ns / 1ps

module tb_lz_rep_offset_decoder_unit;
	import lzrep_pkg::*;

	localparam int WINDOW   = 65536;
	localparam int MAX_COPY = 512;
	// unused action code, the block ignores it
	localparam action_t ACT_NONE = 2'd3;

	typedef logic [LEN_W-1:0] len_t;

	typedef struct {
		action_t   act;
		byte_t     lit;
		rep_kind_t kind;
		offset_t   ofs;
		len_t      len;
		logic      bs;
	} cmd_t;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last;
		logic        err;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [7:0]  literal_byte;
	logic [1:0]  rep_kind;
	logic [16:0] new_offset;
	logic [9:0]  match_length;
	logic        block_start;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] data_bytes;
	logic [3:0]  byte_count;
	logic        last;
	logic        error;

	// decoder shadow state
	byte_t       hist_mem [0:WINDOW-1];
	logic [15:0] wr_ptr   = '0;
	logic [16:0] fill_cnt = '0;
	offset_t     rep0     = '0;
	offset_t     rep1     = '0;
	offset_t     rep2     = '0;

	cmd_t pending_q[$];
	cmd_t cur_cmd;
	res_t out_expect_q[$];

	int gap_max      = 3;
	int stall_max    = 4;
	int hold_len     = 0;
	bit hold_req     = 1'b0;
	int mismatches   = 0;
	int items_taken  = 0;
	int results_seen = 0;
	int err_results  = 0;
	int matches_seen = 0;

	lz_rep_offset_decoder_unit #(
		.WINDOW_SIZE(WINDOW),
		.MAX_MATCH  (MAX_COPY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.literal_byte(literal_byte),
		.rep_kind    (rep_kind),
		.new_offset  (new_offset),
		.match_length(match_length),
		.block_start (block_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_bytes  (data_bytes),
		.byte_count  (byte_count),
		.last        (last),
		.error       (error)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#15_000_000;
		$display("Timeout: decoder stopped making progress");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic void store_byte(byte_t b);
		hist_mem[wr_ptr] = b;
		wr_ptr = wr_ptr + 16'd1;
		if (fill_cnt < WINDOW)
			fill_cnt = fill_cnt + 17'd1;
	endfunction

	function automatic void push_result(logic [63:0] data, logic [3:0] cnt, logic lst, logic err);
		res_t r;
		r.data = data;
		r.cnt  = cnt;
		r.last = lst;
		r.err  = err;
		out_expect_q.push_back(r);
	endfunction

	// Expected output words for one accepted transaction; updates the shadow state.
	function automatic void decode_cmd(cmd_t c);
		offset_t     span;
		int          n;
		int          cnt;
		logic [63:0] word;
		logic [15:0] src;
		byte_t       b;
		if (c.bs) begin
			rep0     = '0;
			rep1     = '0;
			rep2     = '0;
			fill_cnt = '0;
		end
		case (c.act)
		ACT_LIT: begin
			store_byte(c.lit);
			push_result({56'd0, c.lit}, 4'd1, 1'b1, 1'b0);
		end
		ACT_PRE: begin
			store_byte(c.lit);
		end
		ACT_MATCH: begin
			matches_seen++;
			case (c.kind)
			REP_0: begin
				span = rep0;
			end
			REP_1: begin
				span = rep1;
				rep1 = rep0;
				rep0 = span;
			end
			REP_2: begin
				span = rep2;
				rep2 = rep1;
				rep1 = rep0;
				rep0 = span;
			end
			default: begin
				span = c.ofs;
				rep2 = rep1;
				rep1 = rep0;
				rep0 = c.ofs;
			end
			endcase
			if (span == '0 || span > fill_cnt) begin
				push_result(64'd0, 4'd0, 1'b1, 1'b1);
			end else begin
				n = (c.len > MAX_COPY) ? MAX_COPY : int'(c.len);
				if (n == 0) begin
					push_result(64'd0, 4'd0, 1'b1, 1'b0);
				end else begin
					word = '0;
					cnt  = 0;
					// byte at a time so overlapping copies see freshly written bytes
					for (int i = 0; i < n; i++) begin
						src = wr_ptr - span[15:0];
						b   = hist_mem[src];
						store_byte(b);
						word[8*cnt +: 8] = b;
						cnt++;
						if (cnt == 8 || i == n - 1) begin
							push_result(word, cnt[3:0], i == n - 1, 1'b0);
							word = '0;
							cnt  = 0;
						end
					end
				end
			end
		end
		default: begin
		end
		endcase
	endfunction

	// Input side: one transaction presented at a time, in bursts separated by gaps.
	initial begin : drive_inputs
		int burst_left;
		int gap_left;
		bit took;
		burst_left   = 0;
		gap_left     = 0;
		in_valid     = 1'b0;
		action       = ACT_LIT;
		literal_byte = '0;
		rep_kind     = REP_0;
		new_offset   = '0;
		match_length = '0;
		block_start  = 1'b0;
		forever begin
			@(posedge clk);
			took = in_valid && !in_stall;
			if (took) begin
				decode_cmd(cur_cmd);
				items_taken++;
			end
			if (!in_valid || took) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					cur_cmd = pending_q.pop_front();
					in_valid     <= 1'b1;
					action       <= cur_cmd.act;
					literal_byte <= cur_cmd.lit;
					rep_kind     <= cur_cmd.kind;
					new_offset   <= cur_cmd.ofs;
					match_length <= cur_cmd.len;
					block_start  <= cur_cmd.bs;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left   = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: alternating go/stall runs, or a long hold-off on request.
	initial begin : drive_out_stall
		int run_left;
		int hold_left;
		bit stalling;
		run_left  = 0;
		hold_left = 0;
		stalling  = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stalling = !stalling && (stall_max > 0);
					run_left = stalling ? $urandom_range(1, stall_max) : $urandom_range(1, 24);
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	always @(posedge clk) begin : check_outputs
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (error === 1'b1)
				err_results++;
			if (out_expect_q.size() == 0) begin
				report_mismatch("unexpected result", data_bytes, 64'd0);
			end else begin
				want = out_expect_q.pop_front();
				if (data_bytes !== want.data)
					report_mismatch("data_bytes", data_bytes, want.data);
				if (byte_count !== want.cnt)
					report_mismatch("byte_count", 64'(byte_count), 64'(want.cnt));
				if (last !== want.last)
					report_mismatch("last", 64'(last), 64'(want.last));
				if (error !== want.err)
					report_mismatch("error", 64'(error), 64'(want.err));
			end
		end
	end

	task automatic send_item(action_t act, byte_t lit, rep_kind_t kind, offset_t ofs, len_t len,
			logic bs);
		cmd_t c;
		c.act  = act;
		c.lit  = lit;
		c.kind = kind;
		c.ofs  = ofs;
		c.len  = len;
		c.bs   = bs;
		while (pending_q.size() != 0)
			@(negedge clk);
		pending_q.push_back(c);
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || in_valid || out_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_literal_preload();
		send_item(ACT_LIT,  8'h00, REP_0, '0, '0, 1'b1);
		send_item(ACT_LIT,  8'hFF, REP_0, '0, '0, 1'b0);
		send_item(ACT_PRE,  8'hA5, REP_0, '0, '0, 1'b0);
		send_item(ACT_PRE,  8'h5A, REP_0, '0, '0, 1'b0);
		send_item(ACT_NONE, 8'hFF, REP_NEW, 17'h1FFFF, 10'h3FF, 1'b0);
		send_item(ACT_LIT,  8'h3C, REP_0, '0, '0, 1'b0);
	endtask

	task automatic test_match_kinds();
		// overlapping copy, then build a three-deep repeat list
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd1, 10'd20, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd3, 10'd8,  1'b0);
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd5, 10'd9,  1'b0);
		send_item(ACT_MATCH, 8'h00, REP_0,   '0,    10'd7,  1'b0);
		send_item(ACT_MATCH, 8'h00, REP_1,   '0,    10'd3,  1'b0);
		send_item(ACT_MATCH, 8'h00, REP_2,   '0,    10'd16, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_0,   '0,    10'd0,  1'b0);
		send_item(ACT_MATCH, 8'h00, REP_0,   '0,    10'h3FF, 1'b0);
		// zero and out-of-range distances still rotate the list
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd0,     10'd4, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'h1FFFF, 10'd4, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_2,   '0,        10'd5, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_1,   '0,        10'd5, 1'b0);
		// block start: offsets cleared, history fill restarts
		send_item(ACT_LIT,   8'h81, REP_0,   '0,    10'd0, 1'b1);
		send_item(ACT_MATCH, 8'h00, REP_0,   '0,    10'd6, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd2, 10'd6, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd1, 10'd12, 1'b1);
	endtask

	task automatic test_full_window();
		int filled;
		int hi;
		send_item(ACT_LIT, byte_t'($urandom_range(0, 255)), REP_0, '0, '0, 1'b1);
		filled = 1;
		repeat (7) begin
			send_item(ACT_PRE, byte_t'($urandom_range(0, 255)), REP_0, '0, '0, 1'b0);
			filled++;
		end
		// 128 full-length copies overrun the window and wrap the write pointer
		for (int m = 0; m < 128; m++) begin
			hi = (filled > WINDOW) ? WINDOW : filled;
			send_item(ACT_MATCH, 8'h00, REP_NEW, offset_t'($urandom_range(1, hi)),
				(m % 5 == 0) ? len_t'($urandom_range(513, 1023)) : len_t'(MAX_COPY), 1'b0);
			filled += MAX_COPY;
		end
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd65536, 10'd64, 1'b0);
		send_item(ACT_MATCH, 8'h00, REP_NEW, 17'd65537, 10'd8,  1'b0);
		send_item(ACT_MATCH, 8'h00, REP_1,   '0,        10'd24, 1'b0);
	endtask

	task automatic test_output_holdoff();
		// history is full here, so any distance up to the window is valid
		gap_max   = 0;
		stall_max = 0;
		hold_len  = 400;
		hold_req  = 1'b1;
		repeat (8)
			send_item(ACT_MATCH, byte_t'($urandom_range(0, 255)), REP_NEW,
				offset_t'($urandom_range(1, WINDOW)), len_t'($urandom_range(8, 40)), 1'b0);
	endtask

	task automatic test_random_stream(int n_items);
		int        blk_fill;
		int        pick;
		int        span_hi;
		action_t   act;
		byte_t     lit;
		rep_kind_t kind;
		offset_t   ofs;
		len_t      len;
		logic      bs;
		blk_fill = 0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				gap_max   = $urandom_range(0, 6);
				stall_max = $urandom_range(0, 8);
			end
			bs = (i == 0) || ($urandom_range(0, 29) == 0);
			if (bs)
				blk_fill = 0;
			span_hi = (blk_fill > WINDOW) ? WINDOW : blk_fill;
			act  = ACT_MATCH;
			lit  = byte_t'($urandom_range(0, 255));
			kind = rep_kind_t'($urandom_range(0, 3));
			ofs  = offset_t'($urandom_range(0, 17'h1FFFF));
			len  = ($urandom_range(0, 9) == 0) ? len_t'($urandom_range(25, 1023))
				: len_t'($urandom_range(1, 24));
			pick = $urandom_range(0, 99);
			if (pick < 22 || blk_fill == 0) begin
				act = ACT_LIT;
			end else if (pick < 30) begin
				act = ACT_PRE;
			end else if (pick < 34) begin
				act = ACT_NONE;
			end else if (pick < 38) begin
				kind = REP_NEW;
				ofs  = offset_t'($urandom_range(span_hi + 1, 17'h1FFFF));
			end else if (pick < 40) begin
				kind = REP_NEW;
				ofs  = offset_t'($urandom_range(1, span_hi));
				len  = '0;
			end else if (kind == REP_NEW) begin
				ofs = offset_t'($urandom_range(1, span_hi));
			end
			send_item(act, lit, kind, ofs, len, bs);
			// lower bound on history fill, so fresh distances stay valid
			if (act == ACT_LIT || act == ACT_PRE)
				blk_fill++;
			else if (act == ACT_MATCH && kind == REP_NEW && ofs != '0 && ofs <= span_hi)
				blk_fill += (len > MAX_COPY) ? MAX_COPY : int'(len);
		end
	endtask

	initial begin : run_tests
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_literal_preload();
		wait_drained();
		test_match_kinds();
		wait_drained();
		gap_max   = 2;
		stall_max = 2;
		test_full_window();
		wait_drained();
		test_output_holdoff();
		wait_drained();
		test_random_stream(24);
		wait_drained();
		repeat (64) @(posedge clk);

		$display("Checked %0d results from %0d transactions (%0d matches, %0d distance errors),",
			results_seen, items_taken, matches_seen, err_results);
		$display("with all repeat kinds, overlapping and full-window copies, and output hold-offs.");
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
